// ===== hw/rtl/uer_pkg.sv =====
`timescale 1ns / 1ps

package uer_pkg;

    localparam int TIMEOUT_W  = 20;
    localparam int TRIG_W     = 8;
    localparam int SCALE_W    = 16;
    localparam int ECHO_W     = 20;
    localparam int DIST_W     = 15;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 20'd1000000;
    localparam logic [TRIG_W-1:0]    TRIG_WIDTH_RST = 8'd10;
    localparam logic [TRIG_W-1:0]    PRELOW_RST     = 8'd2;
    localparam logic [SCALE_W-1:0]   SCALE_RST      = 16'd2252;
    localparam logic [DIST_W-1:0]    DIST_MAX       = 15'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT    = 2'd0,
        CFG_TRIG_WIDTH = 2'd1,
        CFG_PRELOW     = 2'd2,
        CFG_SCALE      = 2'd3
    } uer_cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRELOW  = 3'd1,
        PH_TRIG    = 3'd2,
        PH_WAIT    = 3'd3,
        PH_MEASURE = 3'd4
    } uer_phase_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_us;
        logic [TRIG_W-1:0]    trigger_width_us;
        logic [TRIG_W-1:0]    prelow_us;
    } uer_cfg_t;

    typedef struct packed {
        logic trigger_out;
        logic busy;
        logic done;
        logic timed_out;
    } uer_flags_t;

endpackage

// ===== hw/rtl/uer_if.sv =====
`timescale 1ns / 1ps

interface uer_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic echo_level;

    modport source (output valid, output start_request, output echo_level, input ready);
    modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

interface uer_out_if
    import uer_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              trigger_out;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [ECHO_W-1:0] echo_width_us;
    logic [DIST_W-1:0] distance_cm;

    modport source (
        output valid, output trigger_out, output busy_res, output done_res,
        output timed_out, output echo_width_us, output distance_cm,
        input  ready
    );
    modport sink (
        input  valid, input trigger_out, input busy_res, input done_res,
        input  timed_out, input echo_width_us, input distance_cm,
        output ready
    );
endinterface

// ===== hw/rtl/uer_seq.sv =====
`timescale 1ns / 1ps

module uer_seq
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   start_request,
    input  logic                   echo_level,
    input  uer_cfg_t               cfg,
    output uer_flags_t             flags,
    output logic [COUNT_WIDTH-1:0] width
);

    localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

    uer_phase_t             phase_reg, phase_next;
    logic [TRIG_W-1:0]      trig_cnt_reg, trig_cnt_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0] pulse_reg, pulse_next;
    uer_flags_t             flags_reg, flags_next;
    logic [COUNT_WIDTH-1:0] width_reg, width_next;
    logic                   limit_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            trig_cnt_reg <= '0;
            elapsed_reg  <= '0;
            pulse_reg    <= '0;
        end
        else if (load)
        begin
            phase_reg    <= phase_next;
            trig_cnt_reg <= trig_cnt_next;
            elapsed_reg  <= elapsed_next;
            pulse_reg    <= pulse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_next;
            width_reg <= width_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        trig_cnt_next = trig_cnt_reg;
        elapsed_next  = elapsed_reg;
        pulse_next    = pulse_reg;
        flags_next    = '0;
        width_next    = '0;
        limit_hit     = 1'b0;

        case (phase_reg)
            PH_IDLE, PH_PRELOW, PH_TRIG, PH_WAIT, PH_MEASURE: ;
            default: phase_next = PH_IDLE;
        endcase

        // Finished phases fall through within the same beat.
        if (phase_next == PH_IDLE && start_request)
        begin
            phase_next    = PH_PRELOW;
            trig_cnt_next = '0;
        end

        if (phase_next == PH_PRELOW)
        begin
            if (trig_cnt_next < cfg.prelow_us)
                trig_cnt_next = trig_cnt_next + 1'b1;
            else
            begin
                phase_next    = PH_TRIG;
                trig_cnt_next = '0;
            end
        end

        if (phase_next == PH_TRIG)
        begin
            if (trig_cnt_next < cfg.trigger_width_us)
            begin
                flags_next.trigger_out = 1'b1;
                trig_cnt_next          = trig_cnt_next + 1'b1;
            end
            else
            begin
                phase_next   = PH_WAIT;
                elapsed_next = '0;
                pulse_next   = '0;
            end
        end

        if (phase_next == PH_WAIT)
        begin
            // Test the limit before this beat's tick is counted.
            limit_hit = (CMP_W'(elapsed_next) >= CMP_W'(cfg.timeout_us))
                     || (&elapsed_next);
            if (echo_level)
                phase_next = PH_MEASURE;
            else if (limit_hit)
            begin
                phase_next           = PH_IDLE;
                flags_next.done      = 1'b1;
                flags_next.timed_out = 1'b1;
            end
            else
                elapsed_next = elapsed_next + 1'b1;
        end

        if (phase_next == PH_MEASURE && !flags_next.done)
        begin
            limit_hit = (CMP_W'(elapsed_next) >= CMP_W'(cfg.timeout_us))
                     || (&elapsed_next);
            if (echo_level)
            begin
                if (limit_hit)
                begin
                    phase_next           = PH_IDLE;
                    flags_next.done      = 1'b1;
                    flags_next.timed_out = 1'b1;
                end
                else
                begin
                    elapsed_next = elapsed_next + 1'b1;
                    pulse_next   = pulse_next + 1'b1;
                end
            end
            else
            begin
                phase_next      = PH_IDLE;
                flags_next.done = 1'b1;
                width_next      = pulse_next;
            end
        end

        flags_next.busy = (phase_next != PH_IDLE);
    end

    assign flags = flags_reg;
    assign width = width_reg;

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps

// Trigger/echo range finder. Each input beat is one microsecond tick carrying
// a start request and the sampled echo level; each accepted beat yields exactly
// one output beat with the trigger level, busy/done status and, on the done
// tick, the echo width in microseconds and the distance in centimeters
// (floor(width/2) * half_width_scale / 65536, saturated to 32767; zero on
// timeout). One beat is accepted every cycle while the output side takes
// results. The sequencer registers phase, counters and flags on the edge that
// accepts a beat; the output register then takes them and the distance
// product when it is empty or being drained. A stalled output holds the output
// register, and in_ch.ready drops once the sequencer also holds a beat.
// Configuration is written through cfg_we/cfg_index/cfg_data, only while no
// beat is in flight; the user must keep to this, the block does not enforce it.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    uer_in_if.sink                in_ch,
    uer_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HALF_W = COUNT_WIDTH - 1;
    localparam int PROD_W = HALF_W + SCALE_W;

    uer_cfg_t               cfg_reg;
    logic [SCALE_W-1:0]     scale_reg;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   s2_load;
    logic                   accept;
    uer_flags_t             s1_flags;
    logic [COUNT_WIDTH-1:0] s1_width;

    logic [HALF_W-1:0]      half;
    logic [PROD_W-1:0]      product;
    logic [HALF_W-1:0]      dist_raw;
    logic [DIST_W-1:0]      dist_sat;

    uer_flags_t             out_flags_reg;
    logic [ECHO_W-1:0]      out_width_reg;
    logic [DIST_W-1:0]      out_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_us       <= TIMEOUT_RST;
            cfg_reg.trigger_width_us <= TRIG_WIDTH_RST;
            cfg_reg.prelow_us        <= PRELOW_RST;
            scale_reg                <= SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (uer_cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:    cfg_reg.timeout_us       <= cfg_data[TIMEOUT_W-1:0];
                CFG_TRIG_WIDTH: cfg_reg.trigger_width_us <= cfg_data[TRIG_W-1:0];
                CFG_PRELOW:     cfg_reg.prelow_us        <= cfg_data[TRIG_W-1:0];
                CFG_SCALE:      scale_reg                <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance the output register when it is empty or being drained.
    assign s2_load      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = !s1_valid_reg || s2_load;
    assign accept       = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
        out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    uer_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .start_request (in_ch.start_request),
        .echo_level    (in_ch.echo_level),
        .cfg           (cfg_reg),
        .flags         (s1_flags),
        .width         (s1_width)
    );

    // Width is zero unless the beat finished normally, so distance follows.
    assign half     = s1_width[COUNT_WIDTH-1:1];
    assign product  = PROD_W'(half) * PROD_W'(scale_reg);
    assign dist_raw = product[PROD_W-1:SCALE_W];
    assign dist_sat = (dist_raw > HALF_W'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            out_flags_reg <= s1_flags;
            out_width_reg <= ECHO_W'(s1_width);
            out_dist_reg  <= dist_sat;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.trigger_out   = out_flags_reg.trigger_out;
    assign out_ch.busy_res      = out_flags_reg.busy;
    assign out_ch.done_res      = out_flags_reg.done;
    assign out_ch.timed_out     = out_flags_reg.timed_out;
    assign out_ch.echo_width_us = out_width_reg;
    assign out_ch.distance_cm   = out_dist_reg;

endmodule

// ===== hw/rtl/uer_checker.sv =====
`timescale 1ns / 1ps

module uer_checker
    import uer_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              trigger_out,
    input logic              busy_res,
    input logic              done_res,
    input logic              timed_out,
    input logic [ECHO_W-1:0] echo_width_us,
    input logic [DIST_W-1:0] distance_cm
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(done_res)
            && $stable(echo_width_us) && $stable(distance_cm))
        else $error("output beat changed while stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done beat still reports busy");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> !timed_out && echo_width_us == '0 && distance_cm == '0)
        else $error("result fields set without done");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> echo_width_us == '0 && distance_cm == '0)
        else $error("timed out beat carries a measurement");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_out |-> busy_res && !done_res)
        else $error("trigger driven outside a measurement");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .trigger_out   (out_ch.trigger_out),
    .busy_res      (out_ch.busy_res),
    .done_res      (out_ch.done_res),
    .timed_out     (out_ch.timed_out),
    .echo_width_us (out_ch.echo_width_us),
    .distance_cm   (out_ch.distance_cm)
);
